[hw/rtl/bmpfb_pkg.sv]
// ----------------------------------------------------------------------------
// bmpfb_pkg
// Shared types and constants of the bmp to framebuffer blitter.
// ----------------------------------------------------------------------------
package bmpfb_pkg;

    // header layout of a 24-bit bmp file
    localparam int HEADER_BYTES  = 54;
    localparam int HDR_IDX_W     = 6;
    localparam int HDR_SIZE_LO   = 2;
    localparam int HDR_SIZE_HI   = 5;
    localparam int HDR_WIDTH_LO  = 18;
    localparam int HDR_WIDTH_HI  = 21;
    localparam int HDR_HEIGHT_LO = 22;
    localparam int HDR_HEIGHT_HI = 25;

    // field widths
    localparam int DIM_W        = 13;   // holds any screen dimension up to 8191
    localparam int PIXEL_W      = 24;
    localparam int ADDR_OUT_W   = 19;
    localparam int ORIGIN_X_W   = 10;
    localparam int ORIGIN_Y_W   = 9;
    localparam int CFG_DATA_W   = 10;
    localparam int OUT_TDATA_W  = 48;
    localparam int TOKEN_QUEUE_DEPTH = 4;

    // configuration register indexes
    typedef enum logic {
        CFG_ORIGIN_X = 1'b0,
        CFG_ORIGIN_Y = 1'b1
    } t_cfg_index;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_HDR_OK    = 2'd1,
        KIND_TOO_LARGE = 2'd2,
        KIND_NO_FIT    = 2'd3
    } t_kind;

    // token kinds from parser to writer
    typedef enum logic {
        TOK_HDR = 1'b0,
        TOK_PIX = 1'b1
    } t_tok_tag;

    // writer state
    typedef enum logic {
        PH_IDLE   = 1'b0,
        PH_PIXELS = 1'b1
    } t_phase;

    // one parsed event; header fields are only meaningful for TOK_HDR
    typedef struct packed {
        t_tok_tag             tag;
        logic                 too_large;
        logic                 w_over;
        logic                 h_over;
        logic [DIM_W-1:0]     width;
        logic [DIM_W-1:0]     height;
        logic [PIXEL_W-1:0]   pixel;
    } t_token;

endpackage

[hw/rtl/bmpfb_fifo.sv]
// ----------------------------------------------------------------------------
// bmpfb_fifo
// Small flop-based token queue between the parser and the writer.
// ----------------------------------------------------------------------------
module bmpfb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/bmpfb_front.sv]
// ----------------------------------------------------------------------------
// bmpfb_front
// Byte parser: walks the bmp header, captures size and dimensions, and
// packs data bytes into pixels, producing one token per event.
// ----------------------------------------------------------------------------
module bmpfb_front
    import bmpfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_file_start,
    output logic       o_push,
    output t_token     o_token
);

    localparam logic [31:0] SIZE_LIMIT =
        32'(SCREEN_WIDTH * SCREEN_HEIGHT * 3 + HEADER_BYTES);

    logic [HDR_IDX_W-1:0] r_idx,    n_idx;
    logic [31:0]          r_size,   n_size;
    logic [31:0]          r_width,  n_width;
    logic [31:0]          r_height, n_height;
    logic                 r_in_hdr, n_in_hdr;
    logic [1:0]           r_bip,    n_bip;
    logic [15:0]          r_part,   n_part;
    logic [1:0]           lane;

    // header walk and pixel packing
    always_comb begin
        n_idx    = r_idx;
        n_size   = r_size;
        n_width  = r_width;
        n_height = r_height;
        n_in_hdr = r_in_hdr;
        n_bip    = r_bip;
        n_part   = r_part;
        lane     = '0;
        o_push   = 1'b0;
        o_token  = '0;
        if (i_accept) begin
            if (i_file_start) begin
                n_idx    = '0;
                n_size   = '0;
                n_width  = '0;
                n_height = '0;
                n_in_hdr = 1'b1;
            end
            if (n_in_hdr) begin
                if (n_idx inside {[HDR_SIZE_LO:HDR_SIZE_HI]}) begin
                    lane = 2'(n_idx - HDR_IDX_W'(HDR_SIZE_LO));
                    n_size[8*lane +: 8] = i_byte;
                end else if (n_idx inside {[HDR_WIDTH_LO:HDR_WIDTH_HI]}) begin
                    lane = 2'(n_idx - HDR_IDX_W'(HDR_WIDTH_LO));
                    n_width[8*lane +: 8] = i_byte;
                end else if (n_idx inside {[HDR_HEIGHT_LO:HDR_HEIGHT_HI]}) begin
                    lane = 2'(n_idx - HDR_IDX_W'(HDR_HEIGHT_LO));
                    n_height[8*lane +: 8] = i_byte;
                end
                if (n_idx == HDR_IDX_W'(HEADER_BYTES - 1)) begin
                    // last header byte: classify the file
                    o_push            = 1'b1;
                    o_token.tag       = TOK_HDR;
                    o_token.too_large = (n_size > SIZE_LIMIT);
                    o_token.w_over    = (n_width > 32'(SCREEN_WIDTH));
                    o_token.h_over    = (n_height > 32'(SCREEN_HEIGHT));
                    o_token.width     = n_width[DIM_W-1:0];
                    o_token.height    = n_height[DIM_W-1:0];
                    n_idx    = '0;
                    n_in_hdr = 1'b0;
                    n_bip    = '0;
                    n_part   = '0;
                end else begin
                    n_idx = n_idx + 1'b1;
                end
            end else if (r_bip != 2'd2) begin
                n_part[8*r_bip[0] +: 8] = i_byte;
                n_bip = r_bip + 1'b1;
            end else begin
                o_push        = 1'b1;
                o_token.tag   = TOK_PIX;
                o_token.pixel = {i_byte, r_part};
                n_bip  = '0;
                n_part = '0;
            end
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_size   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_in_hdr <= 1'b1;
            r_bip    <= '0;
            r_part   <= '0;
        end else begin
            r_idx    <= n_idx;
            r_size   <= n_size;
            r_width  <= n_width;
            r_height <= n_height;
            r_in_hdr <= n_in_hdr;
            r_bip    <= n_bip;
            r_part   <= n_part;
        end
    end

endmodule

[hw/rtl/bmpfb_back.sv]
// ----------------------------------------------------------------------------
// bmpfb_back
// Writer: checks the header against the screen and origin, then walks the
// image rows bottom-up and issues framebuffer writes into an output register.
// ----------------------------------------------------------------------------
module bmpfb_back
    import bmpfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    input  t_token                 i_token,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_kind,
    output logic [ADDR_OUT_W-1:0]  o_addr,
    output logic [PIXEL_W-1:0]     o_pixel,
    output logic                   o_last
);

    localparam int AW  = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
    localparam int CLW = $clog2(SCREEN_WIDTH);
    localparam int RLW = $clog2(SCREEN_HEIGHT);
    localparam int SW  = DIM_W + 1;

    logic [ORIGIN_X_W-1:0] r_ox;
    logic [ORIGIN_Y_W-1:0] r_oy;
    t_phase                r_phase, n_phase;
    logic [DIM_W-1:0]      r_w, n_w;
    logic [DIM_W-1:0]      r_h, n_h;
    logic [CLW-1:0]        r_col, n_col;
    logic [RLW-1:0]        r_row, n_row;
    logic [AW-1:0]         r_row_base, n_row_base;
    logic                  r_valid;
    t_kind                 r_kind, n_kind;
    logic [ADDR_OUT_W-1:0] r_addr, n_addr;
    logic [PIXEL_W-1:0]    r_pixel, n_pixel;
    logic                  r_last, n_last;
    logic                  n_emit;

    logic                  fit_fail;
    logic                  empty;
    logic                  hdr_ok;
    logic                  col_end;
    logic                  row_end;
    logic [SW-1:0]         row_start;
    logic [AW-1:0]         pix_addr;

    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_addr  = r_addr;
    assign o_pixel = r_pixel;
    assign o_last  = r_last;

    // header checks and pixel position
    always_comb begin
        fit_fail = i_token.w_over || i_token.h_over
                   || (SW'(i_token.width) + SW'(r_ox) > SW'(SCREEN_WIDTH))
                   || (SW'(i_token.height) + SW'(r_oy) > SW'(SCREEN_HEIGHT));
        empty     = (i_token.width == '0) || (i_token.height == '0);
        hdr_ok    = !i_token.too_large && !fit_fail && !empty;
        col_end   = (DIM_W'(r_col) + 1'b1 >= r_w);
        row_end   = (DIM_W'(r_row) + 1'b1 >= r_h);
        row_start = SW'(r_oy) + SW'(i_token.height) - 1'b1;
        pix_addr  = r_row_base + AW'(r_col);
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (o_pop) begin
            if (i_token.tag == TOK_HDR) begin
                n_phase = hdr_ok ? PH_PIXELS : PH_IDLE;
            end else if (r_phase == PH_PIXELS && col_end && row_end) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // result and counters
    always_comb begin
        n_emit     = 1'b0;
        n_kind     = r_kind;
        n_addr     = r_addr;
        n_pixel    = r_pixel;
        n_last     = r_last;
        n_w        = r_w;
        n_h        = r_h;
        n_col      = r_col;
        n_row      = r_row;
        n_row_base = r_row_base;
        if (o_pop) begin
            if (i_token.tag == TOK_HDR) begin
                n_emit     = 1'b1;
                n_addr     = '0;
                n_pixel    = '0;
                n_w        = i_token.width;
                n_h        = i_token.height;
                n_col      = '0;
                n_row      = '0;
                n_row_base = AW'(32'(row_start) * 32'(SCREEN_WIDTH) + 32'(r_ox));
                if (i_token.too_large) begin
                    n_kind = KIND_TOO_LARGE;
                    n_last = 1'b1;
                end else if (fit_fail) begin
                    n_kind = KIND_NO_FIT;
                    n_last = 1'b1;
                end else begin
                    n_kind = KIND_HDR_OK;
                    n_last = empty;
                end
            end else if (r_phase == PH_PIXELS) begin
                n_emit  = 1'b1;
                n_kind  = KIND_PIXEL;
                n_addr  = ADDR_OUT_W'(pix_addr);
                n_pixel = i_token.pixel;
                n_last  = col_end && row_end;
                if (col_end) begin
                    n_col = '0;
                    if (!row_end) begin
                        n_row      = r_row + 1'b1;
                        n_row_base = r_row_base - AW'(SCREEN_WIDTH);
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0;
            r_oy <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ORIGIN_X: r_ox <= i_cfg_data[ORIGIN_X_W-1:0];
                CFG_ORIGIN_Y: r_oy <= i_cfg_data[ORIGIN_Y_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_valid <= 1'b0;
            r_w     <= '0;
            r_h     <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_phase <= n_phase;
            r_w     <= n_w;
            r_h     <= n_h;
            r_col   <= n_col;
            r_row   <= n_row;
            if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (n_emit) begin
                r_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_row_base <= n_row_base;
        r_kind     <= n_kind;
        r_addr     <= n_addr;
        r_pixel    <= n_pixel;
        r_last     <= n_last;
    end

endmodule

[hw/rtl/bmp_to_framebuffer_blit.sv]
// ----------------------------------------------------------------------------
// bmp_to_framebuffer_blit
// Streams a 24-bit bmp file in and issues framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the file one byte per transfer; tuser = 1 on the first
//   byte of a file restarts the header parser. m_axis carries one result per
//   status or pixel: tuser is the kind (pixel write, header accepted, file too
//   large, image does not fit), tlast marks the final pixel, an error or an
//   accepted empty image. Origin registers are written through the cfg port
//   only while no file is in flight; the user must keep to this, the block
//   does not enforce it. Throughput is one byte per cycle while the token
//   queue has room, so a pixel write for every third byte; the parser and
//   the writer each take one token per cycle when not stalled. The token of
//   an accepted byte enters the queue and moves from there into the output
//   register once the writer can take it.
//   Rows are addressed bottom-up with one add per pixel and one subtract of
//   the screen width per row; the row start is formed once per header.
//   Reset clears both origins to zero and puts the parser at header byte 0.
//   When m_axis stalls, the output register holds and the four-entry token
//   queue fills; s_axis_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module bmp_to_framebuffer_blit
    import bmpfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // byte stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // data_byte
    input  logic                   s_axis_tuser,   // file_start
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // fb_address[18:0], pixel[42:19]
    output logic [1:0]             m_axis_tuser,   // kind
    output logic                   m_axis_tlast
);

    logic                  q_ready;
    logic                  q_valid;
    logic                  q_pop;
    logic                  f_push;
    t_token                f_token;
    t_token                q_token;
    logic [ADDR_OUT_W-1:0] b_addr;
    logic [PIXEL_W-1:0]    b_pixel;

    assign s_axis_tready = q_ready;

    // parser
    bmpfb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (s_axis_tvalid && q_ready),
        .i_byte       (s_axis_tdata),
        .i_file_start (s_axis_tuser),
        .o_push       (f_push),
        .o_token      (f_token)
    );

    // token queue
    bmpfb_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (TOKEN_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_token),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_token),
        .i_pop   (q_pop)
    );

    // writer
    bmpfb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (q_valid),
        .i_token     (q_token),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_addr      (b_addr),
        .o_pixel     (b_pixel),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - ADDR_OUT_W - PIXEL_W)'(0), b_pixel, b_addr};

endmodule

[dv/bmp_to_framebuffer_blit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_to_framebuffer_blit_tb
// Self-checking bench for the bmp blitter. Streams 24-bit bmp files,
// both well formed and broken, through the byte port, with random gaps
// on both streams. A scoreboard tracks the header parser and the
// bottom-up pixel addressing. It predicts every status and pixel write
// and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module bmp_to_framebuffer_blit_tb;
    import bmpfb_pkg::*;

    localparam int SCR_W          = 800;
    localparam int SCR_H          = 480;
    localparam int SIZE_LIMIT     = SCR_W * SCR_H * 3 + HEADER_BYTES;
    localparam int ITEM_TARGET    = 1150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRINTED    = 100;

    // parser position of the predicted block
    typedef enum {PS_HEADER, PS_PIXELS, PS_DONE} t_parse_state;

    // one expected result transfer
    typedef struct {
        t_kind                 kind;
        logic [ADDR_OUT_W-1:0] addr;
        logic [PIXEL_W-1:0]    pix;
        logic                  last;
    } t_blit_result;

    // tracks the parser and holds the writes and statuses still due
    class t_blit_checker;
        bit [ORIGIN_X_W-1:0] org_x;
        bit [ORIGIN_Y_W-1:0] org_y;
        bit [HDR_IDX_W-1:0]  hdr_pos;
        bit [31:0]           img_w;
        bit [31:0]           img_h;
        bit [31:0]           file_size;
        bit [9:0]            col;
        bit [8:0]            row;
        bit [15:0]           part;
        bit [1:0]            nbytes;
        t_parse_state        st;
        t_blit_result        writes_due[$];
        int                  errors;
        int                  n_used;
        int                  n_ignored;
        int                  n_files;
        int                  kind_seen[4];

        function new();
            org_x = '0;
            org_y = '0;
            restart();
        endfunction

        function void restart();
            hdr_pos   = '0;
            img_w     = '0;
            img_h     = '0;
            file_size = '0;
            col       = '0;
            row       = '0;
            part      = '0;
            nbytes    = '0;
            st        = PS_HEADER;
        endfunction

        function void set_origin(bit [9:0] x, bit [9:0] y);
            org_x = x;
            org_y = y[ORIGIN_Y_W-1:0];
        endfunction

        function int pending();
            return writes_due.size();
        endfunction

        // advance the parser by one accepted byte and queue what it causes
        function void take_byte(bit [7:0] b, bit start);
            int           idx;
            longint       fs;
            longint       wx;
            longint       hy;
            longint       srow;
            longint       scol;
            longint       ncol;
            longint       nrow;
            t_blit_result r;
            if (start)
                restart();
            if (st == PS_DONE) begin
                n_ignored++;
                return;
            end
            n_used++;
            if (st == PS_HEADER) begin
                idx = hdr_pos;
                if (idx >= HDR_SIZE_LO && idx <= HDR_SIZE_HI)
                    file_size |= 32'(b) << (8 * (idx - HDR_SIZE_LO));
                else if (idx >= HDR_WIDTH_LO && idx <= HDR_WIDTH_HI)
                    img_w |= 32'(b) << (8 * (idx - HDR_WIDTH_LO));
                else if (idx >= HDR_HEIGHT_LO && idx <= HDR_HEIGHT_HI)
                    img_h |= 32'(b) << (8 * (idx - HDR_HEIGHT_LO));
                if (idx + 1 < HEADER_BYTES) begin
                    hdr_pos = hdr_pos + 1'b1;
                    return;
                end
                // last header byte: size first, then fit, then empty image
                hdr_pos = '0;
                fs = file_size;
                wx = img_w;
                wx = wx + org_x;
                hy = img_h;
                hy = hy + org_y;
                r.addr = '0;
                r.pix  = '0;
                r.last = 1'b1;
                st     = PS_DONE;
                if (fs > SIZE_LIMIT) begin
                    r.kind = KIND_TOO_LARGE;
                end else if (wx > SCR_W || hy > SCR_H) begin
                    r.kind = KIND_NO_FIT;
                end else if (img_w == 0 || img_h == 0) begin
                    r.kind = KIND_HDR_OK;
                end else begin
                    r.kind = KIND_HDR_OK;
                    r.last = 1'b0;
                    st     = PS_PIXELS;
                    col    = '0;
                    row    = '0;
                    nbytes = '0;
                    part   = '0;
                end
                writes_due.push_back(r);
                return;
            end
            // pixel phase: gather two bytes, the third completes a write
            if (nbytes < 2) begin
                part   = part | (16'(b) << (8 * nbytes));
                nbytes = nbytes + 1'b1;
                return;
            end
            srow = org_y;
            srow = srow + img_h - 1 - row;
            scol = org_x;
            scol = scol + col;
            r.kind = KIND_PIXEL;
            r.addr = ADDR_OUT_W'(srow * SCR_W + scol);
            r.pix  = {b, part};
            r.last = 1'b0;
            nbytes = '0;
            part   = '0;
            ncol = col;
            ncol = ncol + 1;
            nrow = row;
            nrow = nrow + 1;
            if (ncol >= longint'(img_w)) begin
                col = '0;
                if (nrow >= longint'(img_h)) begin
                    r.last = 1'b1;
                    st     = PS_DONE;
                end else begin
                    row = row + 1'b1;
                end
            end else begin
                col = col + 1'b1;
            end
            writes_due.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            if (errors < MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // compare one result transfer with the oldest expectation
        task check_result(logic [1:0] kind, logic [ADDR_OUT_W-1:0] addr,
                          logic [PIXEL_W-1:0] pix, logic last);
            t_blit_result w;
            if (writes_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind %0d addr %0d", kind, addr));
                return;
            end
            w = writes_due.pop_front();
            kind_seen[w.kind]++;
            if (kind !== w.kind)
                flag_mismatch($sformatf("kind %0d, want %0d", kind, w.kind));
            if (addr !== w.addr)
                flag_mismatch($sformatf("fb_address %0d, want %0d", addr, w.addr));
            if (pix !== w.pix)
                flag_mismatch($sformatf("pixel %06h, want %06h", pix, w.pix));
            if (last !== w.last)
                flag_mismatch($sformatf("last %0b, want %0b", last, w.last));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // data_byte
    logic                   s_axis_tuser;   // file_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // fb_address[18:0], pixel[42:19]
    logic [1:0]             m_axis_tuser;   // kind
    logic                   m_axis_tlast;

    t_blit_checker board = new();
    bit            calm;
    int            idle_cycles;

    bmp_to_framebuffer_blit #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // result checking and the no-progress watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tuser, m_axis_tdata[ADDR_OUT_W-1:0],
                                   m_axis_tdata[ADDR_OUT_W +: PIXEL_W], m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results due",
                         idle_cycles, board.pending());
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side backpressure
    initial begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    // one byte transfer; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] d, input logic start);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
        board.take_byte(d, start);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] header_byte(int i, bit [31:0] fsize,
                                               bit [31:0] w, bit [31:0] h);
        if (i == 0)
            return 8'h42;
        if (i == 1)
            return 8'h4D;
        if (i >= HDR_SIZE_LO && i <= HDR_SIZE_HI)
            return fsize[8 * (i - HDR_SIZE_LO) +: 8];
        if (i >= HDR_WIDTH_LO && i <= HDR_WIDTH_HI)
            return w[8 * (i - HDR_WIDTH_LO) +: 8];
        if (i >= HDR_HEIGHT_LO && i <= HDR_HEIGHT_HI)
            return h[8 * (i - HDR_HEIGHT_LO) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    // header (possibly cut short), then pixel bytes if the header was whole
    task automatic send_file(input bit first_start, input bit [31:0] fsize,
                             input bit [31:0] w, input bit [31:0] h,
                             input int hdr_len, input int data_len);
        for (int i = 0; i < hdr_len; i++)
            send_byte(header_byte(i, fsize, w, h), (i == 0) ? first_start : 1'b0);
        if (hdr_len == HEADER_BYTES)
            for (int k = 0; k < data_len; k++)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
        board.n_files++;
    endtask

    // stop the byte stream and wait until the block has nothing in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_origin(input bit [9:0] x, input bit [9:0] y);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ORIGIN_X;
        i_cfg_data  <= x;
        @(negedge i_clk);
        i_cfg_index <= CFG_ORIGIN_Y;
        i_cfg_data  <= y;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_origin(x, y);
    endtask

    function automatic bit [9:0] pick_origin(int scr, int max_field);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 10'd0;
        if (r == 1)
            return 10'(scr - 1);
        if (r == 2)
            return 10'(scr - 3);
        if (r == 3)
            return 10'($urandom_range(scr, max_field));
        return 10'($urandom_range(0, scr - 1));
    endfunction

    // stray bytes between files; a set start bit opens a header that is dropped
    task automatic send_noise();
        repeat ($urandom_range(1, 6))
            send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
    endtask

    // mostly well formed small images, the rest errors and broken files
    task automatic send_random_file();
        int unsigned maxw;
        int unsigned maxh;
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int          data_len;
        int          hdr_len;
        bit [31:0]   fsize;
        maxw = (board.org_x < SCR_W) ? SCR_W - board.org_x : 0;
        maxh = (board.org_y < SCR_H) ? SCR_H - board.org_y : 0;
        w = (maxw == 0) ? 1 : $urandom_range(1, (maxw < 3) ? maxw : 3);
        h = (maxh == 0) ? 1 : $urandom_range(1, (maxh < 3) ? maxh : 3);
        r = $urandom_range(0, 99);
        if (r >= 40 && r < 45 && maxw > 0) begin
            // a wider strip to walk the column counter further
            w = (maxw < 20) ? maxw : $urandom_range(8, 20);
            h = (maxh < 2) ? 1 : $urandom_range(1, 2);
        end
        fsize    = HEADER_BYTES + w * h * 3;
        data_len = w * h * 3;
        hdr_len  = HEADER_BYTES;
        if (r < 8) begin
            if (r < 2)
                fsize = 32'hFFFF_FFFF;
            else if (r < 4)
                fsize = SIZE_LIMIT;
            else
                fsize = SIZE_LIMIT + 1 + $urandom_range(0, 1 << 20);
            if (r >= 4 || r < 2)
                data_len = $urandom_range(0, 4);
        end else if (r < 16) begin
            if (r < 10)
                w = maxw + 1 + $urandom_range(0, 2);
            else if (r < 12)
                h = maxh + 1 + $urandom_range(0, 2);
            else if (r < 14)
                w = $urandom;
            else
                h = $urandom | 32'h8000_0000;
            data_len = $urandom_range(0, 4);
        end else if (r < 21) begin
            if (r[0])
                w = 0;
            else
                h = 0;
            data_len = $urandom_range(0, 4);
        end else if (r < 26) begin
            hdr_len = $urandom_range(1, HEADER_BYTES - 1);
        end else if (r < 31) begin
            data_len = $urandom_range(0, data_len - 1);
        end else if (r < 40) begin
            data_len += $urandom_range(1, 6);
        end
        send_file(1'b1, fsize, w, h, hdr_len, data_len);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_ORIGIN_X;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        calm          = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first file without a start flag, parser is at header byte 0 after reset
        send_file(1'b0, HEADER_BYTES + 12, 2, 2, HEADER_BYTES, 12);
        // size just over the limit, trailing bytes ignored
        send_file(1'b1, SIZE_LIMIT + 1, 1, 1, HEADER_BYTES, 4);
        // size exactly at the limit is accepted
        send_file(1'b1, SIZE_LIMIT, 1, 1, HEADER_BYTES, 3);
        // oversize and no fit together: size wins
        send_file(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, HEADER_BYTES, 0);
        // width near the 32-bit top must not wrap into a fit
        send_file(1'b1, 60, 32'hFFFF_FFFF, 1, HEADER_BYTES, 2);
        // empty images: zero width, zero height, full-width empty, one too wide
        send_file(1'b1, HEADER_BYTES, 0, 5, HEADER_BYTES, 3);
        send_file(1'b1, HEADER_BYTES, 3, 0, HEADER_BYTES, 0);
        send_file(1'b1, HEADER_BYTES, SCR_W, 0, HEADER_BYTES, 0);
        send_file(1'b1, HEADER_BYTES, SCR_W + 1, 0, HEADER_BYTES, 0);
        // restart in the middle of the pixels and of the header
        send_file(1'b1, HEADER_BYTES + 12, 2, 2, HEADER_BYTES, 7);
        send_file(1'b1, HEADER_BYTES + 12, 2, 2, 30, 0);
        send_file(1'b1, HEADER_BYTES + 6, 1, 2, HEADER_BYTES, 6);

        // bottom right corner: last screen word
        settle();
        write_origin(SCR_W - 1, SCR_H - 1);
        send_file(1'b1, HEADER_BYTES + 3, 1, 1, HEADER_BYTES, 3);
        send_file(1'b1, HEADER_BYTES + 6, 2, 1, HEADER_BYTES, 0);
        send_file(1'b1, HEADER_BYTES + 6, 1, 2, HEADER_BYTES, 0);
        // image flush against the right and bottom edges
        settle();
        write_origin(SCR_W - 3, SCR_H - 3);
        send_file(1'b1, HEADER_BYTES + 27, 3, 3, HEADER_BYTES, 27);
        // origin beyond the screen, upper origin bit dropped by the register
        settle();
        write_origin(10'h3FF, 10'h3FF);
        send_file(1'b1, HEADER_BYTES + 3, 1, 1, HEADER_BYTES, 3);

        // random phases
        while (board.n_used + board.n_ignored < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                settle();
                write_origin(pick_origin(SCR_W, 1023), pick_origin(SCR_H, 511));
            end
            repeat ($urandom_range(1, 3)) begin
                send_random_file();
                if ($urandom_range(0, 5) == 0)
                    send_noise();
            end
        end

        // drain
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d files: %0d bytes parsed, %0d bytes ignored after an end",
                 board.n_files, board.n_used, board.n_ignored);
        $display("results: %0d pixel writes, %0d accepted, %0d too large, %0d no fit",
                 board.kind_seen[KIND_PIXEL], board.kind_seen[KIND_HDR_OK],
                 board.kind_seen[KIND_TOO_LARGE], board.kind_seen[KIND_NO_FIT]);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
hw/rtl/bmpfb_pkg.sv
hw/rtl/bmpfb_fifo.sv
hw/rtl/bmpfb_front.sv
hw/rtl/bmpfb_back.sv
hw/rtl/bmp_to_framebuffer_blit.sv
dv/bmp_to_framebuffer_blit_tb.sv
